>>> hw/rtl/ppru_pkg.sv
package ppru_pkg;

    // source image geometry
    localparam int SOURCE_WIDTH    = 320;
    localparam int SOURCE_HEIGHT   = 200;
    localparam int WORDS_PER_ROW   = SOURCE_WIDTH / 4;
    localparam int OUT_ROW_WORDS_2 = (SOURCE_WIDTH * 2) / 4;
    localparam int OUT_ROW_WORDS_3 = (SOURCE_WIDTH * 3) / 4;

    // field and counter widths
    localparam int PX_W    = 32;
    localparam int ADDR_W  = 18;
    localparam int SCALE_W = 2;
    localparam int COL_W   = $clog2(WORDS_PER_ROW);
    localparam int ROW_W   = $clog2(SOURCE_HEIGHT + 1);
    localparam int STEP_W  = 2;

    // scale register codes
    localparam logic [SCALE_W-1:0] SCALE_TWO   = 2'd2;
    localparam logic [SCALE_W-1:0] SCALE_THREE = 2'd3;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // one classified input word
    typedef struct packed {
        logic [PX_W-1:0]   px;
        logic              s3;
        logic [ADDR_W-1:0] base;
    } t_desc;

    // source pixel index for each output byte, by scale and output word
    typedef logic [1:0] t_sel_row [0:3];
    localparam t_sel_row SEL2 [0:1] = '{
        '{2'd0, 2'd0, 2'd1, 2'd1},
        '{2'd2, 2'd2, 2'd3, 2'd3}
    };
    localparam t_sel_row SEL3 [0:2] = '{
        '{2'd0, 2'd0, 2'd0, 2'd1},
        '{2'd1, 2'd1, 2'd2, 2'd2},
        '{2'd2, 2'd3, 2'd3, 2'd3}
    };

    // build output word j of a replicated source word
    function automatic logic [PX_W-1:0] expand_word(
        input logic [PX_W-1:0]   px,
        input logic              s3,
        input logic [STEP_W-1:0] j
    );
        logic [PX_W-1:0] w;
        logic [1:0]      sel;
        w = '0;
        for (int b = 0; b < 4; b++) begin
            if (s3) begin
                sel = (j == 2'd3) ? 2'd3 : SEL3[j][b];
            end else begin
                sel = SEL2[j[0]][b];
            end
            w[8*b +: 8] = px[8*sel +: 8];
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/packed_pixel_replication_upscaler.sv
// Pixel replication upscaler, 2x or 3x, on packed 8-bit pixel words.
// Input side is a queue write port: a beat of i_pixel_word is taken when
// push is high and full is low. Words arrive in raster order, four pixels
// per word, pixel 0 in the low byte.
// Result side is a queue read port: while empty is low the oldest write
// (o_out_address, o_out_data, o_last) is shown and leaves when pop is high.
// Each input word gives scale*scale result beats (4 or 9), output word
// columns outer, output rows inner; o_last marks the final one.
// Scale is set through i_cfg_valid/i_cfg_data (o_cfg_ready is always high)
// and is sampled as each word is taken; values other than 3 mean 2x.
// The first result beat passes the queue entry, the stepper and the output
// register; the back-end stepper gives one result beat per cycle while pop
// keeps up and words are queued; a 2-entry queue lets the input run ahead.
// When pop stays low the output register holds, the stepper stops and the
// queue fills, after which full goes high.
// Reset clears the queue, the output register, the column and row
// counters, and sets scale to 2x.
module packed_pixel_replication_upscaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ppru_pkg::SCALE_W-1:0]  i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [ppru_pkg::PX_W-1:0]     i_pixel_word,
    output logic                          empty,
    input  logic                          pop,
    output logic [ppru_pkg::ADDR_W-1:0]   o_out_address,
    output logic [ppru_pkg::PX_W-1:0]     o_out_data,
    output logic                          o_last
);
    import ppru_pkg::*;

    logic  q_push;
    t_desc q_in_desc;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    t_desc q_out_desc;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;

    // classify input words and track raster position
    ppru_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .push         (push),
        .i_pixel_word (i_pixel_word),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_desc     (q_in_desc)
    );

    // decoupling queue
    ppru_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_out_desc)
    );

    // replicate into output writes
    ppru_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_desc      (q_out_desc),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_address (o_out_address),
        .o_out_data    (o_out_data),
        .o_last        (o_last)
    );

endmodule

>>> hw/rtl/ppru_front.sv
module ppru_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ppru_pkg::SCALE_W-1:0]  i_cfg_data,
    input  logic                          push,
    input  logic [ppru_pkg::PX_W-1:0]     i_pixel_word,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output ppru_pkg::t_desc               o_q_desc
);
    import ppru_pkg::*;

    localparam int BASE_W = ADDR_W + 8;

    logic [SCALE_W-1:0] r_scale;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic               s3;
    logic               accept;
    logic [BASE_W-1:0]  row_words;
    logic [BASE_W-1:0]  row_base;
    logic [BASE_W-1:0]  col_base;

    // scale register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_TWO;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    assign s3     = (r_scale == SCALE_THREE);
    assign accept = push && !i_q_full;

    // base address of the top-left output word for this beat
    always_comb begin
        row_words = BASE_W'(r_row) * BASE_W'(WORDS_PER_ROW);
        if (s3) begin
            row_base = (row_words << 3) + row_words;
            col_base = (BASE_W'(r_col) << 1) + BASE_W'(r_col);
        end else begin
            row_base = row_words << 2;
            col_base = BASE_W'(r_col) << 1;
        end
    end

    assign o_q_push      = accept;
    assign o_q_desc.px   = i_pixel_word;
    assign o_q_desc.s3   = s3;
    assign o_q_desc.base = ADDR_W'(row_base + col_base);

    // raster position, wraps at row and frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == COL_W'(WORDS_PER_ROW - 1)) begin
                r_col <= '0;
                if (r_row == ROW_W'(SOURCE_HEIGHT - 1)) begin
                    r_row <= '0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/ppru_queue.sv
module ppru_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppru_pkg::t_desc i_desc,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ppru_pkg::t_desc o_desc
);
    import ppru_pkg::*;

    t_desc              r_mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_desc  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("queue fill count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

endmodule

>>> hw/rtl/ppru_back.sv
module ppru_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  ppru_pkg::t_desc               i_q_desc,
    output logic                          o_q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [ppru_pkg::ADDR_W-1:0]   o_out_address,
    output logic [ppru_pkg::PX_W-1:0]     o_out_data,
    output logic                          o_last
);
    import ppru_pkg::*;

    logic               r_busy;
    t_desc              r_desc;
    logic [STEP_W-1:0]  r_j;
    logic [STEP_W-1:0]  r_k;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_col_addr;
    logic               r_out_valid;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [PX_W-1:0]    r_out_data;
    logic               r_out_last;

    logic [STEP_W-1:0]  smax;
    logic [ADDR_W-1:0]  row_step;
    logic               advance;
    logic               emit;
    logic               last_beat;
    logic               load;

    assign smax      = r_desc.s3 ? 2'd2 : 2'd1;
    assign row_step  = r_desc.s3 ? ADDR_W'(OUT_ROW_WORDS_3) : ADDR_W'(OUT_ROW_WORDS_2);
    assign advance   = !r_out_valid || pop;
    assign emit      = advance && r_busy;
    assign last_beat = (r_j == smax) && (r_k == smax);
    assign load      = advance && i_q_valid && (!r_busy || last_beat);
    assign o_q_pop   = load;

    // step through output words, rows inner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (load) begin
            r_busy <= 1'b1;
        end else if (emit && last_beat) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc     <= i_q_desc;
            r_j        <= '0;
            r_k        <= '0;
            r_addr     <= i_q_desc.base;
            r_col_addr <= i_q_desc.base;
        end else if (emit) begin
            if (r_k == smax) begin
                r_k        <= '0;
                r_j        <= r_j + 1'b1;
                r_col_addr <= r_col_addr + 1'b1;
                r_addr     <= r_col_addr + 1'b1;
            end else begin
                r_k    <= r_k + 1'b1;
                r_addr <= r_addr + row_step;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_addr <= r_addr;
            r_out_data <= expand_word(r_desc.px, r_desc.s3, r_j);
            r_out_last <= last_beat;
        end
    end

    assign empty         = !r_out_valid;
    assign o_out_address = r_out_addr;
    assign o_out_data    = r_out_data;
    assign o_last        = r_out_last;

    a_steps_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_j <= smax && r_k <= smax))
        else $error("replication step out of range");

    a_load_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_busy && r_j == '0 && r_k == '0 && r_addr == r_col_addr))
        else $error("new word did not restart stepping");

    a_pop_only_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !last_beat) |-> !o_q_pop)
        else $error("queue popped mid word");

endmodule
